// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside of reset.
`define DLPW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define DLPW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== sv/dlpw_pkg.sv =====
package dlpw_pkg;

  // Side of the square coordinate tile is 2**CoordBits.
  localparam int unsigned CoordBits = 6;

  localparam int unsigned InDataBits  = 56;
  localparam int unsigned OutDataBits = 80;
  localparam int unsigned CfgIdxBits  = 1;

  localparam logic [CfgIdxBits-1:0] RegFrameBase = 1'd0;
  localparam logic [CfgIdxBits-1:0] RegRowBytes  = 1'd1;

  localparam logic [15:0] RowBytesReset = 16'd256;

  typedef enum logic {
    StIdle,
    StRun
  } dlpw_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;  // latch a new line command
    logic emit;  // register the current pixel and advance the walk
  } dlpw_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic slot_free;  // output register may take a pixel this cycle
    logic last;       // current pixel is the final one of the line
  } dlpw_sts_t;

endpackage

// ===== sv/dlpw_ctrl.sv =====
module dlpw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output dlpw_pkg::dlpw_cmd_t cmd_o,
  input  dlpw_pkg::dlpw_sts_t sts_i
);
  import dlpw_pkg::*;

  dlpw_state_e state_q, state_d;

  // Next state: run from command transfer until the last pixel is registered.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StRun;
      end
      StRun: begin
        if (sts_i.slot_free && sts_i.last) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      StRun: begin
        cmd_o.emit = sts_i.slot_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/dlpw_datapath.sv =====
module dlpw_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [dlpw_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  logic [31:0]                       cfg_data_i,
  input  logic [dlpw_pkg::InDataBits-1:0]   in_data_i,
  input  dlpw_pkg::dlpw_cmd_t               cmd_i,
  output dlpw_pkg::dlpw_sts_t               sts_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [dlpw_pkg::OutDataBits-1:0]  out_data_o,
  output logic                              out_last_o
);
  import dlpw_pkg::*;

  localparam int unsigned CB = CoordBits;

  // Configuration registers.
  logic [31:0] frame_base_q;
  logic [15:0] row_bytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_base_q <= '0;
      row_bytes_q  <= RowBytesReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegFrameBase: frame_base_q <= cfg_data_i;
        RegRowBytes:  row_bytes_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Unpack the command, keeping the low coordinate bits only.
  logic [CB-1:0] x1_in, y1_in, x2_in, y2_in;
  logic [31:0]   word_in;
  logic [CB:0]   dx, dy;
  logic          xneg_in, yneg_in;
  logic [CB-1:0] xmag_in, ymag_in, steps_in;

  always_comb begin
    x1_in   = in_data_i[CB-1:0];
    y1_in   = in_data_i[6+CB-1:6];
    x2_in   = in_data_i[12+CB-1:12];
    y2_in   = in_data_i[18+CB-1:18];
    // byte order is reversed: alpha goes to word bits [31:24], blue to [7:0]
    word_in = {in_data_i[31:24], in_data_i[39:32], in_data_i[47:40], in_data_i[55:48]};
    dx      = {1'b0, x2_in} - {1'b0, x1_in};
    dy      = {1'b0, y2_in} - {1'b0, y1_in};
    xneg_in = dx[CB];
    yneg_in = dy[CB];
    xmag_in = xneg_in ? CB'(-dx) : dx[CB-1:0];
    ymag_in = yneg_in ? CB'(-dy) : dy[CB-1:0];
    steps_in = (xmag_in > ymag_in) ? xmag_in : ymag_in;
  end

  // Line state: k*mag = q*steps + r on each axis.
  logic [CB-1:0] x1_q, y1_q, xmag_q, ymag_q, steps_q, k_q;
  logic [CB-1:0] xq_q, xr_q, yq_q, yr_q;
  logic          xneg_q, yneg_q;
  logic [31:0]   word_q;

  logic [CB:0]   xsum, ysum;
  logic          xcarry, ycarry;
  logic [CB-1:0] px, py;

  always_comb begin
    xsum   = {1'b0, xr_q} + {1'b0, xmag_q};
    ysum   = {1'b0, yr_q} + {1'b0, ymag_q};
    xcarry = xsum >= {1'b0, steps_q};
    ycarry = ysum >= {1'b0, steps_q};
    // Negative direction: floor of minus the quotient rounds away from start.
    px = xneg_q ? (x1_q - xq_q - CB'(xr_q != '0)) : (x1_q + xq_q);
    py = yneg_q ? (y1_q - yq_q - CB'(yr_q != '0)) : (y1_q + yq_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x1_q    <= x1_in;
      y1_q    <= y1_in;
      xneg_q  <= xneg_in;
      yneg_q  <= yneg_in;
      xmag_q  <= xmag_in;
      ymag_q  <= ymag_in;
      steps_q <= steps_in;
      word_q  <= word_in;
      k_q     <= '0;
      xq_q    <= '0;
      xr_q    <= '0;
      yq_q    <= '0;
      yr_q    <= '0;
    end else if (cmd_i.emit) begin
      // Advance one step; r stays below steps so one subtract suffices.
      k_q  <= k_q + 1'b1;
      xq_q <= xcarry ? xq_q + 1'b1 : xq_q;
      xr_q <= xcarry ? CB'(xsum - {1'b0, steps_q}) : xsum[CB-1:0];
      yq_q <= ycarry ? yq_q + 1'b1 : yq_q;
      yr_q <= ycarry ? CB'(ysum - {1'b0, steps_q}) : ysum[CB-1:0];
    end
  end

  // Byte address of the current pixel.
  logic [CB+15:0] row_off;
  logic [31:0]    addr;

  always_comb begin
    row_off = py * row_bytes_q;
    addr    = frame_base_q + 32'(row_off) + 32'({px, 2'b00});
  end

  // Output register.
  logic              out_valid_q, out_valid_d;
  logic [5:0]        opx_q, opy_q;
  logic [31:0]       oaddr_q, oword_q;
  logic              olast_q;

  assign sts_o.slot_free = !out_valid_q || out_ready_i;
  assign sts_o.last      = (k_q == steps_q);

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit)       out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      opx_q   <= 6'(px);
      opy_q   <= 6'(py);
      oaddr_q <= addr;
      oword_q <= word_q;
      olast_q <= sts_o.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_last_o  = olast_q;
  assign out_data_o  = {4'b0000, oword_q, oaddr_q, opy_q, opx_q};

endmodule

// ===== sv/dda_line_pixel_writer.sv =====
// Channel    | Dir | Handshake                 | Payload
// s_axis     | in  | s_axis_tvalid/tready      | tdata: line command
// m_axis     | out | m_axis_tvalid/tready      | tdata: pixel write, tlast: last pixel
// cfg        | in  | cfg_valid/cfg_ready       | cfg_index, cfg_data
//
// A line of steps = max(|dx|,|dy|) gives steps+1 pixels, one per cycle while m_axis
// is not stalled, set by the single step of the remainder walk and the address multiply per cycle.
// A command is taken only when idle; the next one is taken the cycle after the
// last pixel enters the output register.
// A stall on m_axis holds the output register and freezes the walk.
// Reset is asynchronous: frame_base clears, row_bytes goes to 256.
`include "assert_macros.svh"

module dda_line_pixel_writer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [dlpw_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  logic [31:0]                       cfg_data_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // start_x[5:0] start_y[11:6] end_x[17:12] end_y[23:18]
  // alpha[31:24] red[39:32] green[47:40] blue[55:48]
  input  logic [dlpw_pkg::InDataBits-1:0]   s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // pixel_x[5:0] pixel_y[11:6] pixel_addr[43:12] pixel_word[75:44], zeros above
  output logic [dlpw_pkg::OutDataBits-1:0]  m_axis_tdata_o,
  output logic                              m_axis_tlast_o
);
  import dlpw_pkg::*;

  dlpw_cmd_t cmd;
  dlpw_sts_t sts;

  assign cfg_ready_o = 1'b1;

  dlpw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  dlpw_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

  // No pixel is registered while a command may be taken.
  `DLPW_ASSERT(a_no_emit_when_ready, s_axis_tready_o |-> !cmd.emit, "emit while idle")
  // A pixel never overwrites one that is still stalled.
  `DLPW_ASSERT(a_no_overwrite, cmd.emit |-> (!m_axis_tvalid_o || m_axis_tready_i),
    "output overwritten")
  // After a command transfer the block is busy.
  `DLPW_ASSERT(a_busy_after_load, cmd.load |=> !s_axis_tready_o, "ready after load")

endmodule
